/* design/cle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Byte codes, result kinds, byte classes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_SP  = 8'h20;
    localparam logic [7:0] BYTE_DEL = 8'h7F;

    localparam int         CNT_W       = 6;
    localparam int         LENGTH_CAP  = 61;
    localparam logic [5:0] LIMIT_RESET = 6'd48;

    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_CANCEL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CLS_IGNORE,
        CLS_EOL,
        CLS_CANCEL,
        CLS_BS,
        CLS_CHAR
    } t_cls;

    typedef enum logic [2:0] {
        DSEL_ZERO,
        DSEL_CR,
        DSEL_LF,
        DSEL_BS,
        DSEL_SP,
        DSEL_BEL,
        DSEL_RX,
        DSEL_RAM
    } t_dsel;

    typedef struct packed {
        logic  cap;
        logic  load;
        t_kind kind;
        t_dsel dsel;
        logic  with_len;
        logic  last;
        logic  cnt_clr;
        logic  cnt_dec;
        logic  cnt_inc;
        logic  wr;
        logic  rd;
        logic  idx_clr;
        logic  idx_inc;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic out_free;
        logic cnt_zero;
        logic full;
        logic idx_last;
    } t_sts;

endpackage
`default_nettype wire

/* design/cle_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* design/cle_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_dp: line editor datapath
// Byte capture and classing, character count, line store, read index,
// limit register and the output register.
// ----------------------------------------------------------------------------
module cle_dp import cle_pkg::*; #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_cfg_valid,
    input  wire logic [5:0] i_cfg_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic [5:0]      o_line_length,
    output logic            o_last
);

    localparam int AW      = $clog2(BUFFER_BYTES);
    localparam int CAP     = (BUFFER_BYTES < LENGTH_CAP) ? BUFFER_BYTES : LENGTH_CAP;
    localparam logic [CNT_W-1:0] CAP_W = CNT_W'(CAP);

    logic [7:0]       r_rx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [5:0]       r_limit;
    logic             r_out_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_data;
    logic [5:0]       r_len;
    logic             r_last;

    logic [CNT_W-1:0] eff_limit;
    logic [7:0]       ram_rd_data;
    logic [7:0]       n_data;
    t_cls             cls;

    assign eff_limit = (r_limit > CAP_W) ? CAP_W : r_limit;

    always_comb begin
        unique case (r_rx)
            BYTE_NUL, BYTE_TAB, BYTE_DEL: cls = CLS_IGNORE;
            BYTE_CR, BYTE_LF:             cls = CLS_EOL;
            BYTE_ETX:                     cls = CLS_CANCEL;
            BYTE_BS:                      cls = CLS_BS;
            default:                      cls = CLS_CHAR;
        endcase
    end

    always_comb begin
        unique case (i_cmd.dsel)
            DSEL_CR:  n_data = BYTE_CR;
            DSEL_LF:  n_data = BYTE_LF;
            DSEL_BS:  n_data = BYTE_BS;
            DSEL_SP:  n_data = BYTE_SP;
            DSEL_BEL: n_data = BYTE_BEL;
            DSEL_RX:  n_data = r_rx;
            DSEL_RAM: n_data = ram_rd_data;
            default:  n_data = BYTE_NUL;
        endcase
    end

    assign o_sts.cls      = cls;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.cnt_zero = (r_count == '0);
    assign o_sts.full     = (r_count >= eff_limit);
    assign o_sts.idx_last = ((r_idx + CNT_W'(1)) == r_count);

    cle_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_rx),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_rx <= i_rx_byte;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.load) begin
            r_kind <= i_cmd.kind;
            r_data <= n_data;
            r_len  <= i_cmd.with_len ? r_count : '0;
            r_last <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_data_byte   = r_data;
    assign o_line_length = r_len;
    assign o_last        = r_last;

endmodule
`default_nettype wire

/* design/cle_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_ctrl: line editor controller
// Sequences the results of one received byte and steers the datapath.
// ----------------------------------------------------------------------------
module cle_ctrl import cle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHAR,
        S_EOL_CR,
        S_EOL_LF,
        S_RD,
        S_LINE,
        S_DONE,
        S_CAN_CR,
        S_CAN_LF,
        S_CANCEL,
        S_BS1,
        S_BS2,
        S_BS3
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.cap = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cls)
                    CLS_EOL:    n_state = S_EOL_CR;
                    CLS_CANCEL: n_state = S_CAN_CR;
                    CLS_BS:     n_state = i_sts.cnt_zero ? S_IDLE : S_BS1;
                    CLS_CHAR:   n_state = S_CHAR;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_CHAR: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = KIND_ECHO;
                    o_cmd.dsel    = i_sts.full ? DSEL_BEL : DSEL_RX;
                    o_cmd.last    = 1'b1;
                    o_cmd.wr      = !i_sts.full;
                    o_cmd.cnt_inc = !i_sts.full;
                    n_state       = S_IDLE;
                end
            end
            S_EOL_CR, S_CAN_CR: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.dsel = DSEL_CR;
                    n_state    = (r_state == S_EOL_CR) ? S_EOL_LF : S_CAN_LF;
                end
            end
            S_EOL_LF: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = KIND_ECHO;
                    o_cmd.dsel    = DSEL_LF;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = i_sts.cnt_zero ? S_DONE : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LINE;
            end
            S_LINE: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = KIND_LINE;
                    o_cmd.dsel    = DSEL_RAM;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = i_sts.idx_last ? S_DONE : S_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.kind     = KIND_DONE;
                    o_cmd.dsel     = DSEL_ZERO;
                    o_cmd.with_len = 1'b1;
                    o_cmd.last     = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CAN_LF: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.dsel = DSEL_LF;
                    n_state    = S_CANCEL;
                end
            end
            S_CANCEL: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = KIND_CANCEL;
                    o_cmd.dsel    = DSEL_ZERO;
                    o_cmd.last    = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_BS1: begin
                if (i_sts.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.kind    = KIND_ECHO;
                    o_cmd.dsel    = DSEL_BS;
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_BS2;
                end
            end
            S_BS2: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.dsel = DSEL_SP;
                    n_state    = S_BS3;
                end
            end
            S_BS3: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = KIND_ECHO;
                    o_cmd.dsel = DSEL_BS;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* design/console_line_editor_top.sv */
// Console line editor. Takes one received byte per request and answers with
// echo bytes, finished line bytes and line-complete or cancel markers on a
// registered output. A new byte is taken only once the results of the last
// one are all loaded; at line end each stored byte costs one read of the line
// store and one load of the output register. Output stalls hold the sequence.
// The line limit must be written by the user only while the block is idle;
// the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// console_line_editor_top: canonical-mode console line editor
// Controller, datapath and line store joined by command and status bundles.
// ----------------------------------------------------------------------------
module console_line_editor_top import cle_pkg::*; #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [5:0] i_cfg_line_limit,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic [5:0]      o_line_length,
    output logic            o_last
);

    localparam int CAP = (BUFFER_BYTES < LENGTH_CAP) ? BUFFER_BYTES : LENGTH_CAP;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cle_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_line_limit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_DONE || o_kind == KIND_CANCEL) |-> o_last)
        else $error("marker without last flag");

    a_len_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DONE |-> o_line_length == '0)
        else $error("line length outside complete marker");

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DONE |-> o_line_length <= 6'(CAP))
        else $error("line length beyond limit");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while previous one in work");

    a_no_load_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !o_out_valid || i_out_ready)
        else $error("output register overwritten while stalled");

endmodule
`default_nettype wire
